### sv/qpr_pkg.sv
// shared constants and register index codes for the quasi-pr current controller
package qpr_pkg;

  localparam int unsigned QPR_SAMPLE_WIDTH   = 16;
  localparam int unsigned QPR_COEF_FRAC_BITS = 16;
  localparam int unsigned COEF_WIDTH         = 24;
  localparam int unsigned RES_WIDTH          = 32;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam int unsigned CFG_IDX_W          = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN = 3'd0,
    CFG_RES_B0    = 3'd1,
    CFG_RES_A1    = 3'd2,
    CFG_RES_A2    = 3'd3,
    CFG_DRIVE_MIN = 3'd4,
    CFG_DRIVE_MAX = 3'd5
  } cfg_idx_e;

endpackage

### sv/qpr_fifo.sv
// small register queue used between the parts and on the result side
module qpr_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/qpr_front.sv
// front part: takes error samples, keeps error history, forms feed-forward products
module qpr_front import qpr_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH   = QPR_SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = QPR_COEF_FRAC_BITS,
  parameter int unsigned KP_W           = COEF_WIDTH + SAMPLE_WIDTH,
  parameter int unsigned B0_W           = COEF_WIDTH + SAMPLE_WIDTH + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic signed [SAMPLE_WIDTH-1:0] error_sample_i,
  input  logic signed [COEF_WIDTH-1:0]   prop_gain_i,
  input  logic signed [COEF_WIDTH-1:0]   res_b0_i,
  output logic                           mid_push_o,
  input  logic                           mid_full_i,
  output logic signed [KP_W-1:0]         kp_term_o,
  output logic signed [B0_W-1:0]         b0_term_o
);

  localparam int unsigned DIFF_W = SAMPLE_WIDTH + 1;

  logic                           valid_q, valid_d;
  logic                           load;
  logic signed [SAMPLE_WIDTH-1:0] err1_q, err2_q;
  logic signed [DIFF_W-1:0]       diff;
  logic signed [KP_W-1:0]         kp_prod, kp_term_q;
  logic signed [B0_W-1:0]         b0_prod, b0_term_q;

  assign full_o     = valid_q & mid_full_i;
  assign mid_push_o = valid_q & ~mid_full_i;
  assign load       = push_i & ~full_o;

  assign diff    = DIFF_W'(error_sample_i) - DIFF_W'(err2_q);
  assign kp_prod = prop_gain_i * error_sample_i;
  assign b0_prod = res_b0_i * diff;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (mid_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      err1_q  <= '0;
      err2_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (load) begin
        err2_q <= err1_q;
        err1_q <= error_sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kp_term_q <= kp_prod >>> COEF_FRAC_BITS;
      b0_term_q <= b0_prod >>> COEF_FRAC_BITS;
    end
  end

  assign kp_term_o = kp_term_q;
  assign b0_term_o = b0_term_q;

endmodule

### sv/qpr_back.sv
// back part: resonant recursion with saturation, proportional add and output clamp
module qpr_back import qpr_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH   = QPR_SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = QPR_COEF_FRAC_BITS,
  parameter int unsigned KP_W           = COEF_WIDTH + SAMPLE_WIDTH,
  parameter int unsigned B0_W           = COEF_WIDTH + SAMPLE_WIDTH + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           mid_empty_i,
  output logic                           mid_pop_o,
  input  logic signed [KP_W-1:0]         kp_term_i,
  input  logic signed [B0_W-1:0]         b0_term_i,
  input  logic signed [COEF_WIDTH-1:0]   res_a1_i,
  input  logic signed [COEF_WIDTH-1:0]   res_a2_i,
  input  logic signed [SAMPLE_WIDTH-1:0] drive_min_i,
  input  logic signed [SAMPLE_WIDTH-1:0] drive_max_i,
  input  logic                           out_full_i,
  output logic                           out_push_o,
  output logic signed [SAMPLE_WIDTH-1:0] drive_o
);

  localparam int unsigned FB_W  = COEF_WIDTH + RES_WIDTH;
  localparam int unsigned TOP_W = (RES_WIDTH > SAMPLE_WIDTH + 1) ? RES_WIDTH : SAMPLE_WIDTH + 1;
  localparam int unsigned SUM_W = COEF_WIDTH + TOP_W + 2;
  localparam logic signed [SUM_W-1:0] R_HI = {{(SUM_W-RES_WIDTH+1){1'b0}},
                                              {(RES_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] R_LO = {{(SUM_W-RES_WIDTH+1){1'b1}},
                                              {(RES_WIDTH-1){1'b0}}};

  logic                          work;
  logic signed [RES_WIDTH-1:0]   y1_q, y2_q, r;
  logic signed [FB_W-1:0]        a1_prod, a2_prod, a1_term, a2_term;
  logic signed [SUM_W-1:0]       r_sum, out_sum, lo_ext, hi_ext, clamped;

  assign work       = ~mid_empty_i & ~out_full_i;
  assign mid_pop_o  = work;
  assign out_push_o = work;

  assign a1_prod = res_a1_i * y1_q;
  assign a2_prod = res_a2_i * y2_q;
  assign a1_term = a1_prod >>> COEF_FRAC_BITS;
  assign a2_term = a2_prod >>> COEF_FRAC_BITS;
  assign r_sum   = SUM_W'(b0_term_i) - SUM_W'(a1_term) - SUM_W'(a2_term);

  always_comb begin
    if (r_sum > R_HI) begin
      r = R_HI[RES_WIDTH-1:0];
    end else if (r_sum < R_LO) begin
      r = R_LO[RES_WIDTH-1:0];
    end else begin
      r = r_sum[RES_WIDTH-1:0];
    end
  end

  assign out_sum = SUM_W'(kp_term_i) + SUM_W'(r);
  assign lo_ext  = SUM_W'(drive_min_i);
  assign hi_ext  = SUM_W'(drive_max_i);

  always_comb begin
    if (out_sum < lo_ext) begin
      clamped = lo_ext;
    end else if (out_sum > hi_ext) begin
      clamped = hi_ext;
    end else begin
      clamped = out_sum;
    end
  end

  assign drive_o = clamped[SAMPLE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_q <= '0;
      y2_q <= '0;
    end else if (work) begin
      y2_q <= y1_q;
      y1_q <= r;
    end
  end

endmodule

### sv/quasi_pr_current_controller_top.sv
// top level of the quasi-pr current controller
// Takes one signed error sample per clock while full is low and returns one clamped
// drive sample for each, in order. Sustained rate is one sample per cycle when nothing
// stalls. The front part registers the proportional and b0 products, a two-entry queue
// follows, and the back part closes the resonant recursion through its a1 and a2
// feedback multipliers before a two-entry result queue. Coefficients are signed with
// COEF_FRAC_BITS fraction bits. The user must write them through the configuration port
// only while the block is idle; the block itself does not enforce this.
module quasi_pr_current_controller_top import qpr_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH   = QPR_SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = QPR_COEF_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic signed [SAMPLE_WIDTH-1:0] error_sample_i,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [SAMPLE_WIDTH-1:0] drive_o,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [((SAMPLE_WIDTH > COEF_WIDTH) ? SAMPLE_WIDTH : COEF_WIDTH)-1:0] cfg_data_i
);

  localparam int unsigned KP_W  = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int unsigned B0_W  = COEF_WIDTH + SAMPLE_WIDTH + 1;
  localparam int unsigned MID_W = KP_W + B0_W;

  logic signed [COEF_WIDTH-1:0]   prop_gain_q, res_b0_q, res_a1_q, res_a2_q;
  logic signed [SAMPLE_WIDTH-1:0] drive_min_q, drive_max_q;

  logic                           mid_push, mid_full, mid_pop, mid_empty;
  logic signed [KP_W-1:0]         kp_term_f, kp_term_b;
  logic signed [B0_W-1:0]         b0_term_f, b0_term_b;
  logic [MID_W-1:0]               mid_wdata, mid_rdata;
  logic                           out_push, out_full;
  logic signed [SAMPLE_WIDTH-1:0] drive_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q <= '0;
      res_b0_q    <= '0;
      res_a1_q    <= '0;
      res_a2_q    <= '0;
      drive_min_q <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      drive_max_q <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PROP_GAIN: prop_gain_q <= cfg_data_i[COEF_WIDTH-1:0];
        CFG_RES_B0:    res_b0_q    <= cfg_data_i[COEF_WIDTH-1:0];
        CFG_RES_A1:    res_a1_q    <= cfg_data_i[COEF_WIDTH-1:0];
        CFG_RES_A2:    res_a2_q    <= cfg_data_i[COEF_WIDTH-1:0];
        CFG_DRIVE_MIN: drive_min_q <= cfg_data_i[SAMPLE_WIDTH-1:0];
        CFG_DRIVE_MAX: drive_max_q <= cfg_data_i[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  qpr_front #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .KP_W          (KP_W),
    .B0_W          (B0_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .error_sample_i(error_sample_i),
    .prop_gain_i   (prop_gain_q),
    .res_b0_i      (res_b0_q),
    .mid_push_o    (mid_push),
    .mid_full_i    (mid_full),
    .kp_term_o     (kp_term_f),
    .b0_term_o     (b0_term_f)
  );

  assign mid_wdata = {kp_term_f, b0_term_f};

  qpr_fifo #(
    .WIDTH(MID_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (mid_wdata),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .data_o (mid_rdata),
    .empty_o(mid_empty)
  );

  assign kp_term_b = mid_rdata[MID_W-1:B0_W];
  assign b0_term_b = mid_rdata[B0_W-1:0];

  qpr_back #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .KP_W          (KP_W),
    .B0_W          (B0_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_empty_i(mid_empty),
    .mid_pop_o  (mid_pop),
    .kp_term_i  (kp_term_b),
    .b0_term_i  (b0_term_b),
    .res_a1_i   (res_a1_q),
    .res_a2_i   (res_a2_q),
    .drive_min_i(drive_min_q),
    .drive_max_i(drive_max_q),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .drive_o    (drive_b)
  );

  qpr_fifo #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (drive_b),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (drive_o),
    .empty_o(empty)
  );

endmodule

### sv/qpr_checker.sv
// port-level checks for the quasi-pr current controller, bound to the top level
module qpr_checker import qpr_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = QPR_SAMPLE_WIDTH
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    push,
  input logic                    full,
  input logic                    empty,
  input logic                    pop,
  input logic [SAMPLE_WIDTH-1:0] drive_o
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty && !full)
    else $error("not empty after reset");

  // input can only back up while results are waiting
  a_full_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("full with no waiting result");

  // with the result side drained, the input side frees up by the next cycle
  a_full_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty && !(push && !full) |=> !full)
    else $error("full persists with empty result side");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(drive_o))
    else $error("waiting result changed");

endmodule

bind quasi_pr_current_controller_top qpr_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_qpr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .drive_o(drive_o)
);

### tb/quasi_pr_current_controller_top_tb.sv
// self-checking testbench for the quasi-pr current controller top level
module quasi_pr_current_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qpr_pkg::*;

  localparam int unsigned SW = QPR_SAMPLE_WIDTH;
  localparam int unsigned FRAC = QPR_COEF_FRAC_BITS;
  localparam int unsigned CFG_W = (SW > COEF_WIDTH) ? SW : COEF_WIDTH;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RECV_HOLD_CYCLES = 250;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam longint RES_MAX = 64'sd2147483647;
  localparam longint RES_MIN = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic signed [SW-1:0] error_sample_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [SW-1:0] drive_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  quasi_pr_current_controller_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .error_sample_i (error_sample_i),
    .empty          (empty),
    .pop            (pop),
    .drive_o        (drive_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // predictor copy of configuration and history
  logic signed [COEF_WIDTH-1:0] kp_m = '0;
  logic signed [COEF_WIDTH-1:0] b0_m = '0;
  logic signed [COEF_WIDTH-1:0] a1_m = '0;
  logic signed [COEF_WIDTH-1:0] a2_m = '0;
  logic signed [SW-1:0] drive_min_m = {1'b1, {(SW-1){1'b0}}};
  logic signed [SW-1:0] drive_max_m = {1'b0, {(SW-1){1'b1}}};
  logic signed [SW-1:0] err_prev1_m = '0;
  logic signed [SW-1:0] err_prev2_m = '0;
  logic signed [RES_WIDTH-1:0] res_prev1_m = '0;
  logic signed [RES_WIDTH-1:0] res_prev2_m = '0;

  logic signed [SW-1:0] pending_error_q[$];
  logic signed [SW-1:0] drive_exp_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic recv_hold_start = 1'b0;
  int unsigned recv_hold_left = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  always #2 clk_i = ~clk_i;

  function automatic logic signed [SW-1:0] qpr_next_drive(logic signed [SW-1:0] e);
    longint res_sum;
    longint total;
    res_sum = ((longint'(b0_m) * (longint'(e) - longint'(err_prev2_m))) >>> FRAC)
            - ((longint'(a1_m) * longint'(res_prev1_m)) >>> FRAC)
            - ((longint'(a2_m) * longint'(res_prev2_m)) >>> FRAC);
    if (res_sum > RES_MAX) begin
      res_sum = RES_MAX;
    end else if (res_sum < RES_MIN) begin
      res_sum = RES_MIN;
    end
    err_prev2_m = err_prev1_m;
    err_prev1_m = e;
    res_prev2_m = res_prev1_m;
    res_prev1_m = res_sum[RES_WIDTH-1:0];
    total = ((longint'(kp_m) * longint'(e)) >>> FRAC) + res_sum;
    if (total < longint'(drive_min_m)) begin
      total = longint'(drive_min_m);
    end else if (total > longint'(drive_max_m)) begin
      total = longint'(drive_max_m);
    end
    return total[SW-1:0];
  endfunction

  // request driver
  always @(posedge clk_i) begin : error_driver
    logic next_push;
    logic signed [SW-1:0] next_error;
    next_push = 1'b0;
    next_error = error_sample_i;
    if (rst_ni) begin
      if (push && !full) begin
        drive_exp_q.push_back(qpr_next_drive(error_sample_i));
        pending_error_q.delete(0);
      end
      if (pending_error_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_push = 1'b1;
        next_error = pending_error_q[0];
      end
    end
    push <= next_push;
    error_sample_i <= next_error;
  end

  always @(posedge clk_i) begin : recv_hold_counter
    if (recv_hold_start) begin
      recv_hold_left <= RECV_HOLD_CYCLES;
    end else if (recv_hold_left != 0) begin
      recv_hold_left <= recv_hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin : drive_monitor
    logic next_pop;
    logic signed [SW-1:0] exp_drive;
    next_pop = 1'b0;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (drive_exp_q.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) begin
            $display("unexpected drive result %0d", drive_o);
          end
        end else begin
          exp_drive = drive_exp_q.pop_front();
          if (drive_o !== exp_drive) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10) begin
              $display("drive mismatch: expected %0d, got %0d", exp_drive, drive_o);
            end
          end
        end
      end
      if (recv_hold_left == 0 && !recv_hold_start && $urandom_range(99, 0) >= recv_idle_pct) begin
        next_pop = 1'b1;
      end
    end
    pop <= next_pop;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_PROP_GAIN: kp_m = data[COEF_WIDTH-1:0];
      CFG_RES_B0:    b0_m = data[COEF_WIDTH-1:0];
      CFG_RES_A1:    a1_m = data[COEF_WIDTH-1:0];
      CFG_RES_A2:    a2_m = data[COEF_WIDTH-1:0];
      CFG_DRIVE_MIN: drive_min_m = data[SW-1:0];
      CFG_DRIVE_MAX: drive_max_m = data[SW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_gains(input int kp, input int b0, input int a1, input int a2,
                            input int lo, input int hi);
    logic [CFG_W-1:0] upper;
    upper = CFG_W'($urandom());
    write_reg(CFG_PROP_GAIN, kp[CFG_W-1:0]);
    write_reg(CFG_RES_B0, b0[CFG_W-1:0]);
    write_reg(CFG_RES_A1, a1[CFG_W-1:0]);
    write_reg(CFG_RES_A2, a2[CFG_W-1:0]);
    write_reg(CFG_DRIVE_MIN, {upper[CFG_W-1:SW], lo[SW-1:0]});
    write_reg(CFG_DRIVE_MAX, {upper[CFG_W-SW-1:0], hi[SW-1:0]});
  endtask

  function automatic int rand_coef();
    return int'($urandom_range(16777215, 0)) - 8388608;
  endfunction

  task automatic load_random_gains();
    int kp, b0, a1, a2, lo, hi, tmp;
    if ($urandom_range(9, 0) < 7) begin
      // resonant pole pair near the unit circle
      kp = int'($urandom_range(200000, 0)) - 50000;
      b0 = int'($urandom_range(4000, 0)) - 2000;
      a1 = int'($urandom_range(260000, 0)) - 130000;
      a2 = int'($urandom_range(65500, 55000));
    end else begin
      kp = rand_coef();
      b0 = rand_coef();
      a1 = rand_coef();
      a2 = rand_coef();
    end
    lo = int'($urandom_range(65535, 0)) - 32768;
    hi = int'($urandom_range(65535, 0)) - 32768;
    case ($urandom_range(5, 0))
      0: begin
        lo = -32768;
        hi = 32767;
      end
      1: ;
      default: begin
        if (lo > hi) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
    endcase
    load_gains(kp, b0, a1, a2, lo, hi);
  endtask

  function automatic logic signed [SW-1:0] rand_error();
    logic [SW-1:0] raw;
    raw = SW'($urandom());
    case ($urandom_range(9, 0))
      0: begin
        case ($urandom_range(3, 0))
          0: raw = {1'b1, {(SW-1){1'b0}}};
          1: raw = {1'b0, {(SW-1){1'b1}}};
          2: raw = '0;
          default: raw = '1;
        endcase
      end
      1, 2, 3: raw = SW'(int'($urandom_range(2000, 0)) - 1000);
      default: ;
    endcase
    return raw;
  endfunction

  task automatic queue_errors(input int n);
    repeat (n) pending_error_q.push_back(rand_error());
  endtask

  task automatic wait_drained();
    while (pending_error_q.size() != 0 || push || drive_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_idle_pct = 28;
    recv_idle_pct = 85;

    // reset values: all coefficients zero
    pending_error_q.push_back(16'sd32767);
    pending_error_q.push_back(-16'sd32768);
    pending_error_q.push_back(16'sd0);
    wait_drained();

    // resonant overflow with extreme coefficients
    load_gains(8388607, 8388607, -8388608, 8388607, -32768, 32767);
    pending_error_q.push_back(16'sd32767);
    pending_error_q.push_back(-16'sd32768);
    pending_error_q.push_back(-16'sd32768);
    pending_error_q.push_back(16'sd32767);
    pending_error_q.push_back(16'sd1);
    pending_error_q.push_back(-16'sd1);
    pending_error_q.push_back(16'sd0);
    pending_error_q.push_back(16'sd0);
    wait_drained();

    // crossed limits
    load_gains(-8388608, -8388608, 0, -8388608, 100, -100);
    pending_error_q.push_back(16'sd0);
    pending_error_q.push_back(16'sd50);
    pending_error_q.push_back(-16'sd50);
    pending_error_q.push_back(16'sd32767);
    pending_error_q.push_back(-16'sd32768);
    pending_error_q.push_back(16'sd5);
    wait_drained();

    // spare register indexes must leave the setting unchanged
    write_reg(CFG_IDX_SPARE_LO, CFG_W'($urandom()));
    write_reg(CFG_IDX_SPARE_HI, CFG_W'($urandom()));
    load_gains(65536, 1000, -130000, 65000, 32767, -32768);
    write_reg(CFG_IDX_SPARE_LO, '1);
    pending_error_q.push_back(-16'sd32768);
    pending_error_q.push_back(16'sd32767);
    pending_error_q.push_back(16'sd1234);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        load_random_gains();
        if (phase == 0 && blk == 1) begin
          // long receiver stall so the input side backs up
          @(posedge clk_i);
          recv_hold_start <= 1'b1;
          @(posedge clk_i);
          recv_hold_start <= 1'b0;
          queue_errors(42);
          while (recv_hold_left != 0) @(posedge clk_i);
        end else if (phase == 1 && blk == 2) begin
          queue_errors(20);
          wait_drained();
          queue_errors(22);
        end else begin
          queue_errors(42);
        end
        wait_drained();
      end
    end

    wait_drained();
    if (mismatch_cnt == 0 && drive_exp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
